// ===== sv/hsss_pkg.sv =====
// Shared types, widths and codes of the hardstop seek sweep unit.
`default_nettype none

package hsss_pkg;

    localparam int POS_W   = 18;
    localparam int TICK_W  = 16;
    localparam int RAMP_W  = 12;
    localparam int GAIN_W  = 13;
    localparam int PROD_W  = GAIN_W + RAMP_W;
    localparam int CNT_W   = $clog2(GAIN_W + 1);
    localparam int CFG_W   = 16;
    localparam int FAULT_W = 4;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_ABORT = 2'd2,
        OP_RSVD  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_RUN     = 3'd1,
        ST_STOP    = 3'd2,
        ST_CAP     = 3'd3,
        ST_TIMEOUT = 3'd4,
        ST_FAULT   = 3'd5,
        ST_ABORT   = 3'd6,
        ST_NOFB    = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        CFG_DEADLINE = 3'd0,
        CFG_GRACE    = 3'd1,
        CFG_DWELL    = 3'd2,
        CFG_RAMP     = 3'd3,
        CFG_EPS      = 3'd4,
        CFG_STEP     = 3'd5,
        CFG_LEAD     = 3'd6,
        CFG_KP       = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] mult_a;
        logic [RAMP_W-1:0] mult_b;
        logic [RAMP_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/hsss_div.sv =====
// Shared multiply then restoring divide unit: floor(a * b / d) for b < d.
`default_nettype none

module hsss_div
    import hsss_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAMP_W-1:0] rem_reg, rem_next;
    logic [GAIN_W-1:0] quo_reg, quo_next;
    logic [RAMP_W-1:0] divisor_reg, divisor_next;

    logic [PROD_W-1:0] prod;
    logic [RAMP_W:0]   trial;
    logic [RAMP_W:0]   diff;
    logic              ge;

    always_comb begin
        prod  = PROD_W'(req.mult_a) * PROD_W'(req.mult_b);
        trial = {rem_reg, quo_reg[GAIN_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        ge    = (trial >= {1'b0, divisor_reg});

        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;

        if (req.start) begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(GAIN_W);
            rem_next     = prod[PROD_W-1:GAIN_W];
            quo_next     = prod[GAIN_W-1:0];
            divisor_next = req.divisor;
        end else if (busy_reg && (cnt_reg != '0)) begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = ge ? diff[RAMP_W-1:0] : trial[RAMP_W-1:0];
            quo_next = {quo_reg[GAIN_W-2:0], ge};
        end else if (busy_reg) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            divisor_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            divisor_reg <= divisor_next;
        end
    end

    assign rsp.done     = busy_reg && (cnt_reg == '0);
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/hardstop_seek_sweep_unit.sv =====
// Hardstop seek sweep: sequencer, sweep state and result register.
//
// Usage: each transaction on the s_ channel is one control item (start,
// tick or abort) and yields exactly one transaction on the m_ channel.
// Registers are written through the cfg_ channel (always ready), by the user
// only while the unit is idle; the unit does not enforce this. The unit holds
// one item at a time; s_ready is low from acceptance until the result has
// been loaded into the output register. Each item passes S_RAMP, S_CMD and
// S_EVAL; a tick during the gain/lead ramp also runs two passes of the shared
// multiply-divide unit (13 quotient bits, one per cycle) in S_GAIN and S_LEAD.
// s_ready rises together with m_valid, so an item occupies the input until its
// result is loaded, a wait set by the shared divider and by the receiver.
// The result register lets a new item be accepted while the previous
// result waits; if the receiver stalls, the next result is held internally
// until the output register frees up, then m_valid rises.
// Reset (aresetn low, synchronous) restores register defaults, returns the
// sweep to idle and drops any pending result.
`default_nettype none

module hardstop_seek_sweep_unit
    import hsss_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_opcode,
    input  wire logic                      s_feedback_valid,
    input  wire logic signed [POS_W-1:0]   s_measured_position,
    input  wire logic [FAULT_W-1:0]        s_fault_code,
    input  wire logic                      s_direction,
    input  wire logic                      s_limit_enable,
    input  wire logic signed [POS_W-1:0]   s_travel_limit,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [2:0]                     m_status,
    output logic                           m_command_valid,
    output logic signed [POS_W-1:0]        m_target_position,
    output logic [GAIN_W-1:0]              m_gain_effective,
    output logic signed [POS_W-1:0]        m_stop_position,
    output logic [FAULT_W-1:0]             m_fault_out
);

    localparam int WIDE_W = POS_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAMP,
        S_GAIN,
        S_LEAD,
        S_CMD,
        S_EVAL
    } state_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if ((v[WIDE_W-1:POS_W-1] == '0) || (v[WIDE_W-1:POS_W-1] == '1)) begin
            r = v[POS_W-1:0];
        end else begin
            r = v[WIDE_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration registers
    logic [TICK_W-1:0] deadline_reg, grace_reg, dwell_reg;
    logic [RAMP_W-1:0] ramp_reg, eps_reg, step_reg;
    logic [GAIN_W-1:0] lead_max_reg, kp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadline_reg <= TICK_W'(1500);
            grace_reg    <= TICK_W'(40);
            dwell_reg    <= TICK_W'(30);
            ramp_reg     <= RAMP_W'(40);
            eps_reg      <= RAMP_W'(82);
            step_reg     <= RAMP_W'(49);
            lead_max_reg <= GAIN_W'(492);
            kp_reg       <= GAIN_W'(160);
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_DEADLINE: deadline_reg <= cfg_data[TICK_W-1:0];
                CFG_GRACE:    grace_reg    <= cfg_data[TICK_W-1:0];
                CFG_DWELL:    dwell_reg    <= cfg_data[TICK_W-1:0];
                CFG_RAMP:     ramp_reg     <= cfg_data[RAMP_W-1:0];
                CFG_EPS:      eps_reg      <= cfg_data[RAMP_W-1:0];
                CFG_STEP:     step_reg     <= cfg_data[RAMP_W-1:0];
                CFG_LEAD:     lead_max_reg <= cfg_data[GAIN_W-1:0];
                CFG_KP:       kp_reg       <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, item latch, sweep state, output register
    state_t                  state_reg, state_next;
    opcode_t                 op_reg, op_next;
    logic                    fb_reg, fb_next;
    logic signed [POS_W-1:0] meas_reg, meas_next;
    logic [FAULT_W-1:0]      fcode_reg, fcode_next;
    logic                    dir_reg, dir_next;
    logic                    lim_en_reg, lim_en_next;
    logic signed [POS_W-1:0] lim_in_reg, lim_in_next;

    logic                    run_reg, run_next;
    logic [TICK_W-1:0]       elapsed_reg, elapsed_next;
    logic signed [POS_W-1:0] cmd_pos_reg, cmd_pos_next;
    logic signed [POS_W-1:0] cur_pos_reg, cur_pos_next;
    logic signed [POS_W-1:0] prog_pos_reg, prog_pos_next;
    logic [TICK_W-1:0]       prog_tick_reg, prog_tick_next;
    logic                    positive_reg, positive_next;
    logic                    limit_act_reg, limit_act_next;
    logic signed [POS_W-1:0] limit_pos_reg, limit_pos_next;

    logic [GAIN_W-1:0]       gain_reg, gain_next;
    logic [GAIN_W-1:0]       lead_reg, lead_next;
    logic signed [POS_W-1:0] cmd_calc_reg, cmd_calc_next;
    logic signed [POS_W-1:0] tgt_reg, tgt_next;

    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic                    m_cv_reg, m_cv_next;
    logic signed [POS_W-1:0] m_target_reg, m_target_next;
    logic [GAIN_W-1:0]       m_gain_reg, m_gain_next;
    logic signed [POS_W-1:0] m_stop_reg, m_stop_next;
    logic [FAULT_W-1:0]      m_fault_reg, m_fault_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    hsss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic                     need_div;
    logic signed [WIDE_W-1:0] cmd_sum, bound, tgt_w;
    logic signed [POS_W-1:0]  cmd_sat, cmd_clamp;
    logic signed [POS_W-1:0]  pos_eff;
    logic signed [WIDE_W-1:0] diff_w, abs_w;
    logic                     moved, capped, stalled, out_free;
    logic [TICK_W-1:0]        ptick_eff, since_prog;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        fb_next        = fb_reg;
        meas_next      = meas_reg;
        fcode_next     = fcode_reg;
        dir_next       = dir_reg;
        lim_en_next    = lim_en_reg;
        lim_in_next    = lim_in_reg;
        run_next       = run_reg;
        elapsed_next   = elapsed_reg;
        cmd_pos_next   = cmd_pos_reg;
        cur_pos_next   = cur_pos_reg;
        prog_pos_next  = prog_pos_reg;
        prog_tick_next = prog_tick_reg;
        positive_next  = positive_reg;
        limit_act_next = limit_act_reg;
        limit_pos_next = limit_pos_reg;
        gain_next      = gain_reg;
        lead_next      = lead_reg;
        cmd_calc_next  = cmd_calc_reg;
        tgt_next       = tgt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_cv_next      = m_cv_reg;
        m_target_next  = m_target_reg;
        m_gain_next    = m_gain_reg;
        m_stop_next    = m_stop_reg;
        m_fault_next   = m_fault_reg;

        div_req.start   = 1'b0;
        div_req.mult_a  = kp_reg;
        div_req.mult_b  = elapsed_reg[RAMP_W-1:0];
        div_req.divisor = ramp_reg;

        need_div = (op_reg == OP_TICK) && run_reg && (elapsed_reg < TICK_W'(ramp_reg));
        out_free = !m_valid_reg || m_ready;

        // command step, limit clamp and lead window
        cmd_sum = positive_reg ? WIDE_W'(cmd_pos_reg) + WIDE_W'(step_reg)
                               : WIDE_W'(cmd_pos_reg) - WIDE_W'(step_reg);
        cmd_sat = sat_pos(cmd_sum);
        cmd_clamp = cmd_sat;
        if (limit_act_reg && !positive_reg && (cmd_sat < limit_pos_reg)) begin
            cmd_clamp = limit_pos_reg;
        end
        if (limit_act_reg && positive_reg && (cmd_sat > limit_pos_reg)) begin
            cmd_clamp = limit_pos_reg;
        end
        bound = positive_reg ? WIDE_W'(cur_pos_reg) + WIDE_W'(lead_reg)
                             : WIDE_W'(cur_pos_reg) - WIDE_W'(lead_reg);
        tgt_w = WIDE_W'(cmd_clamp);
        if (!positive_reg && (tgt_w < bound)) begin
            tgt_w = bound;
        end
        if (positive_reg && (tgt_w > bound)) begin
            tgt_w = bound;
        end

        // feedback, progress, cap and stall
        pos_eff    = fb_reg ? meas_reg : cur_pos_reg;
        diff_w     = WIDE_W'(meas_reg) - WIDE_W'(prog_pos_reg);
        abs_w      = diff_w[WIDE_W-1] ? -diff_w : diff_w;
        moved      = fb_reg && (abs_w > WIDE_W'(eps_reg));
        ptick_eff  = moved ? elapsed_reg : prog_tick_reg;
        since_prog = elapsed_reg - ptick_eff;
        capped     = limit_act_reg && ((!positive_reg && (pos_eff <= limit_pos_reg)) ||
                                       (positive_reg && (pos_eff >= limit_pos_reg)));
        stalled    = (elapsed_reg > grace_reg) && (since_prog > dwell_reg);

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = opcode_t'(s_opcode);
                    fb_next     = s_feedback_valid;
                    meas_next   = s_measured_position;
                    fcode_next  = s_fault_code;
                    dir_next    = s_direction;
                    lim_en_next = s_limit_enable;
                    lim_in_next = s_travel_limit;
                    state_next  = S_RAMP;
                end
            end
            S_RAMP: begin
                if (need_div) begin
                    div_req.start = 1'b1;
                    state_next    = S_GAIN;
                end else begin
                    gain_next  = kp_reg;
                    lead_next  = lead_max_reg;
                    state_next = S_CMD;
                end
            end
            S_GAIN: begin
                if (div_rsp.done) begin
                    gain_next      = div_rsp.quotient;
                    div_req.start  = 1'b1;
                    div_req.mult_a = lead_max_reg;
                    state_next     = S_LEAD;
                end
            end
            S_LEAD: begin
                if (div_rsp.done) begin
                    lead_next  = div_rsp.quotient;
                    state_next = S_CMD;
                end
            end
            S_CMD: begin
                cmd_calc_next = cmd_clamp;
                tgt_next      = sat_pos(tgt_w);
                state_next    = S_EVAL;
            end
            S_EVAL: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_IDLE;
                    m_cv_next     = 1'b0;
                    m_target_next = '0;
                    m_gain_next   = '0;
                    m_stop_next   = '0;
                    m_fault_next  = '0;
                    state_next    = S_IDLE;
                    if (op_reg == OP_START) begin
                        if (!fb_reg) begin
                            run_next      = 1'b0;
                            m_status_next = ST_NOFB;
                        end else begin
                            run_next       = 1'b1;
                            elapsed_next   = '0;
                            cmd_pos_next   = meas_reg;
                            cur_pos_next   = meas_reg;
                            prog_pos_next  = meas_reg;
                            prog_tick_next = '0;
                            positive_next  = dir_reg;
                            limit_act_next = lim_en_reg;
                            limit_pos_next = lim_in_reg;
                            m_status_next  = ST_RUN;
                        end
                    end else if (!run_reg || (op_reg == OP_RSVD)) begin
                        m_status_next = run_reg ? ST_RUN : ST_IDLE;
                    end else if (op_reg == OP_ABORT) begin
                        run_next      = 1'b0;
                        m_status_next = ST_ABORT;
                    end else if (elapsed_reg > deadline_reg) begin
                        run_next      = 1'b0;
                        m_status_next = ST_TIMEOUT;
                    end else begin
                        cmd_pos_next  = cmd_calc_reg;
                        m_cv_next     = 1'b1;
                        m_target_next = tgt_reg;
                        m_gain_next   = gain_reg;
                        if (fb_reg && fcode_reg[FAULT_W-1]) begin
                            run_next      = 1'b0;
                            m_status_next = ST_FAULT;
                            m_fault_next  = fcode_reg;
                        end else begin
                            if (fb_reg) begin
                                cur_pos_next = meas_reg;
                            end
                            if (moved) begin
                                prog_pos_next  = meas_reg;
                                prog_tick_next = elapsed_reg;
                            end
                            if (elapsed_reg != '1) begin
                                elapsed_next = elapsed_reg + 1'b1;
                            end
                            if (capped) begin
                                run_next      = 1'b0;
                                m_status_next = ST_CAP;
                                m_stop_next   = limit_pos_reg;
                            end else if (stalled) begin
                                run_next      = 1'b0;
                                m_status_next = ST_STOP;
                                m_stop_next   = pos_eff;
                            end else begin
                                m_status_next = ST_RUN;
                            end
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_START;
            fb_reg        <= 1'b0;
            meas_reg      <= '0;
            fcode_reg     <= '0;
            dir_reg       <= 1'b0;
            lim_en_reg    <= 1'b0;
            lim_in_reg    <= '0;
            run_reg       <= 1'b0;
            elapsed_reg   <= '0;
            cmd_pos_reg   <= '0;
            cur_pos_reg   <= '0;
            prog_pos_reg  <= '0;
            prog_tick_reg <= '0;
            positive_reg  <= 1'b0;
            limit_act_reg <= 1'b0;
            limit_pos_reg <= '0;
            gain_reg      <= '0;
            lead_reg      <= '0;
            cmd_calc_reg  <= '0;
            tgt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            m_status_reg  <= ST_IDLE;
            m_cv_reg      <= 1'b0;
            m_target_reg  <= '0;
            m_gain_reg    <= '0;
            m_stop_reg    <= '0;
            m_fault_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            fb_reg        <= fb_next;
            meas_reg      <= meas_next;
            fcode_reg     <= fcode_next;
            dir_reg       <= dir_next;
            lim_en_reg    <= lim_en_next;
            lim_in_reg    <= lim_in_next;
            run_reg       <= run_next;
            elapsed_reg   <= elapsed_next;
            cmd_pos_reg   <= cmd_pos_next;
            cur_pos_reg   <= cur_pos_next;
            prog_pos_reg  <= prog_pos_next;
            prog_tick_reg <= prog_tick_next;
            positive_reg  <= positive_next;
            limit_act_reg <= limit_act_next;
            limit_pos_reg <= limit_pos_next;
            gain_reg      <= gain_next;
            lead_reg      <= lead_next;
            cmd_calc_reg  <= cmd_calc_next;
            tgt_reg       <= tgt_next;
            m_valid_reg   <= m_valid_next;
            m_status_reg  <= m_status_next;
            m_cv_reg      <= m_cv_next;
            m_target_reg  <= m_target_next;
            m_gain_reg    <= m_gain_next;
            m_stop_reg    <= m_stop_next;
            m_fault_reg   <= m_fault_next;
        end
    end

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_command_valid   = m_cv_reg;
    assign m_target_position = m_target_reg;
    assign m_gain_effective  = m_gain_reg;
    assign m_stop_position   = m_stop_reg;
    assign m_fault_out       = m_fault_reg;

`ifndef SYNTHESIS
    a_one_item_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted while an item is in flight");

    a_command_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command_valid) |->
        ((m_status_reg == ST_RUN) || (m_status_reg == ST_STOP) ||
         (m_status_reg == ST_CAP) || (m_status_reg == ST_FAULT)))
        else $error("command issued with a status that carries none");

    a_fault_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status_reg == ST_FAULT)) |-> m_fault_out[FAULT_W-1])
        else $error("fault status reported without a fault code");

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> ((state_reg == S_RAMP) || (state_reg == S_GAIN)))
        else $error("divider started outside the ramp sequence");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the hardstop seek sweep unit, predicted item by item.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hsss_pkg::*;

    localparam int POS_MAX        = 131071;
    localparam int POS_MIN        = -131072;
    localparam int FAULT_LEVEL    = 8;
    localparam int TICK_SAT       = 65535;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        opcode_t                   op;
        logic                      fb;
        logic signed [POS_W-1:0]   meas;
        logic [FAULT_W-1:0]        code;
        logic                      dir;
        logic                      lim_en;
        logic signed [POS_W-1:0]   limit;
    } sweep_item_t;

    typedef struct packed {
        status_t                   status;
        logic                      cmd_valid;
        logic signed [POS_W-1:0]   target;
        logic [GAIN_W-1:0]         gain;
        logic signed [POS_W-1:0]   stop;
        logic [FAULT_W-1:0]        fault;
    } sweep_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [2:0]               cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_opcode = '0;
    logic                     s_feedback_valid = 1'b0;
    logic signed [POS_W-1:0]  s_measured_position = '0;
    logic [FAULT_W-1:0]       s_fault_code = '0;
    logic                     s_direction = 1'b0;
    logic                     s_limit_enable = 1'b0;
    logic signed [POS_W-1:0]  s_travel_limit = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [2:0]               m_status;
    logic                     m_command_valid;
    logic signed [POS_W-1:0]  m_target_position;
    logic [GAIN_W-1:0]        m_gain_effective;
    logic signed [POS_W-1:0]  m_stop_position;
    logic [FAULT_W-1:0]       m_fault_out;

    // register copies
    int deadline_cfg = 1500;
    int grace_cfg    = 40;
    int dwell_cfg    = 30;
    int ramp_cfg     = 40;
    int eps_cfg      = 82;
    int step_cfg     = 49;
    int lead_cfg     = 492;
    int kp_cfg       = 160;

    // sweep state
    bit sweep_running = 1'b0;
    int tick_count    = 0;
    int command_pos   = 0;
    int joint_pos     = 0;
    int progress_pos  = 0;
    int progress_at   = 0;
    bit sweep_up      = 1'b0;
    bit limit_on      = 1'b0;
    int limit_pos     = 0;

    sweep_item_t   control_items[$];
    sweep_result_t reports_due[$];
    sweep_item_t   drive_item;
    int            gap_left = 0;
    int            items_sent = 0;
    int            results_seen = 0;
    int            stall_left = 0;
    int            hold_left = 0;
    int            next_hold_at = 200;
    int            fail_count = 0;
    int            quiet_cycles = 0;

    hardstop_seek_sweep_unit i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_feedback_valid    (s_feedback_valid),
        .s_measured_position (s_measured_position),
        .s_fault_code        (s_fault_code),
        .s_direction         (s_direction),
        .s_limit_enable      (s_limit_enable),
        .s_travel_limit      (s_travel_limit),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_command_valid     (m_command_valid),
        .m_target_position   (m_target_position),
        .m_gain_effective    (m_gain_effective),
        .m_stop_position     (m_stop_position),
        .m_fault_out         (m_fault_out)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_pos(int v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    function automatic sweep_result_t advance_sweep(sweep_item_t it);
        sweep_result_t r;
        int t, gain, lead, cmd, tgt, pos, d;
        r = '0;
        r.status = ST_IDLE;
        if (it.op == OP_START) begin
            if (!it.fb) begin
                sweep_running = 1'b0;
                r.status = ST_NOFB;
                return r;
            end
            sweep_running = 1'b1;
            tick_count = 0;
            command_pos = int'(it.meas);
            joint_pos = int'(it.meas);
            progress_pos = int'(it.meas);
            progress_at = 0;
            sweep_up = it.dir;
            limit_on = it.lim_en;
            limit_pos = int'(it.limit);
            r.status = ST_RUN;
            return r;
        end
        if (!sweep_running || it.op == OP_RSVD) begin
            r.status = sweep_running ? ST_RUN : ST_IDLE;
            return r;
        end
        if (it.op == OP_ABORT) begin
            sweep_running = 1'b0;
            r.status = ST_ABORT;
            return r;
        end
        t = tick_count;
        if (t > deadline_cfg) begin
            sweep_running = 1'b0;
            r.status = ST_TIMEOUT;
            return r;
        end
        if (t < ramp_cfg) begin
            gain = (kp_cfg * t) / ramp_cfg;
            lead = (lead_cfg * t) / ramp_cfg;
        end else begin
            gain = kp_cfg;
            lead = lead_cfg;
        end
        cmd = clamp_pos(sweep_up ? command_pos + step_cfg : command_pos - step_cfg);
        if (limit_on) begin
            if (!sweep_up && cmd < limit_pos) cmd = limit_pos;
            if (sweep_up && cmd > limit_pos) cmd = limit_pos;
        end
        command_pos = cmd;
        tgt = cmd;
        pos = joint_pos;
        if (!sweep_up && tgt < pos - lead) tgt = pos - lead;
        if (sweep_up && tgt > pos + lead) tgt = pos + lead;
        tgt = clamp_pos(tgt);
        r.cmd_valid = 1'b1;
        r.target = POS_W'(tgt);
        r.gain = GAIN_W'(gain);
        if (it.fb) begin
            if (it.code >= FAULT_LEVEL) begin
                sweep_running = 1'b0;
                r.status = ST_FAULT;
                r.fault = it.code;
                return r;
            end
            joint_pos = int'(it.meas);
            pos = joint_pos;
            d = pos - progress_pos;
            if (d < 0) d = -d;
            if (d > eps_cfg) begin
                progress_pos = pos;
                progress_at = t;
            end
        end
        if (tick_count < TICK_SAT) tick_count++;
        if (limit_on && ((!sweep_up && pos <= limit_pos) || (sweep_up && pos >= limit_pos))) begin
            sweep_running = 1'b0;
            r.status = ST_CAP;
            r.stop = POS_W'(limit_pos);
            return r;
        end
        if (t > grace_cfg && t - progress_at > dwell_cfg) begin
            sweep_running = 1'b0;
            r.status = ST_STOP;
            r.stop = POS_W'(pos);
            return r;
        end
        r.status = ST_RUN;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int any_pos();
        return int'($urandom_range(0, 262143)) - 131072;
    endfunction

    function automatic void push_item(opcode_t op, bit fb, int meas, int code, bit dir,
                                      bit lim_en, int limit);
        sweep_item_t it;
        it.op = op;
        it.fb = fb;
        it.meas = meas[POS_W-1:0];
        it.code = code[FAULT_W-1:0];
        it.dir = dir;
        it.lim_en = lim_en;
        it.limit = limit[POS_W-1:0];
        control_items.push_back(it);
    endfunction

    function automatic void push_noise(opcode_t op);
        push_item(op, 1'($urandom_range(0, 1)), any_pos(), $urandom_range(0, 15),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), any_pos());
    endfunction

    // plant: joint moves toward a hidden stop, then jitters around it
    function automatic int queue_sweep();
        int pos, dsign, stop_at, limit, n_ticks, r, span, top;
        bit up, lim_en, stopped;
        up = 1'($urandom_range(0, 1));
        dsign = up ? 1 : -1;
        case ($urandom_range(0, 4))
            0: pos = POS_MAX - int'($urandom_range(0, 3000));
            1: pos = POS_MIN + int'($urandom_range(0, 3000));
            default: pos = any_pos();
        endcase
        span = 40 * step_cfg + 500;
        stop_at = clamp_pos(pos + dsign * int'($urandom_range(0, span)));
        lim_en = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: limit = any_pos();
            1: limit = clamp_pos(pos - dsign * int'($urandom_range(0, 2000)));
            default: limit = clamp_pos(pos + dsign * int'($urandom_range(0, span)));
        endcase
        push_item(OP_START, $urandom_range(0, 19) != 0, pos, $urandom_range(0, 15), up,
                  lim_en, limit);
        top = (deadline_cfg + 3 < 90) ? deadline_cfg + 3 : 90;
        n_ticks = $urandom_range(1, top);
        stopped = 1'b0;
        for (int k = 0; k < n_ticks; k++) begin
            r = $urandom_range(0, 99);
            if (r == 0) begin
                push_noise(OP_ABORT);
            end else if (r == 1) begin
                push_noise(OP_RSVD);
            end else begin
                if (!stopped) begin
                    pos = pos + dsign * int'($urandom_range(0, step_cfg + step_cfg / 2 + 1));
                    if (dsign * (pos - stop_at) >= 0) begin
                        pos = stop_at;
                        stopped = 1'b1;
                    end
                end else begin
                    pos = stop_at + int'($urandom_range(0, eps_cfg)) - eps_cfg / 2;
                end
                pos = clamp_pos(pos);
                if (r < 10) begin
                    push_item(OP_TICK, 1'b0, any_pos(), $urandom_range(0, 15),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), any_pos());
                end else begin
                    push_item(OP_TICK, 1'b1, pos,
                              (r == 99) ? $urandom_range(FAULT_LEVEL, 15)
                                        : $urandom_range(0, FAULT_LEVEL - 1),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), any_pos());
                end
            end
        end
        return n_ticks + 1;
    endfunction

    task automatic queue_random(int count);
        int made;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 6) == 0) begin
                push_noise(opcode_t'($urandom_range(0, 3)));
                made++;
            end else begin
                made += queue_sweep();
            end
        end
    endtask

    task automatic write_reg(cfg_index_t idx, int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEADLINE: deadline_cfg = value;
            CFG_GRACE:    grace_cfg = value;
            CFG_DWELL:    dwell_cfg = value;
            CFG_RAMP:     ramp_cfg = value;
            CFG_EPS:      eps_cfg = value;
            CFG_STEP:     step_cfg = value;
            CFG_LEAD:     lead_cfg = value;
            CFG_KP:       kp_cfg = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(int dl, int gr, int dw, int rp, int ep, int st, int ld,
                                int kp);
        write_reg(CFG_DEADLINE, dl);
        write_reg(CFG_GRACE, gr);
        write_reg(CFG_DWELL, dw);
        write_reg(CFG_RAMP, rp);
        write_reg(CFG_EPS, ep);
        write_reg(CFG_STEP, st);
        write_reg(CFG_LEAD, ld);
        write_reg(CFG_KP, kp);
    endtask

    // hold off until every queued item has been answered
    task automatic drain();
        do @(negedge aclk);
        while (control_items.size() != 0 || s_valid || reports_due.size() != 0);
        repeat (40) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : item_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                reports_due.push_back(advance_sweep(drive_item));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (control_items.size() != 0) begin
                    drive_item = control_items.pop_front();
                    s_opcode <= drive_item.op;
                    s_feedback_valid <= drive_item.fb;
                    s_measured_position <= drive_item.meas;
                    s_fault_code <= drive_item.code;
                    s_direction <= drive_item.dir;
                    s_limit_enable <= drive_item.lim_en;
                    s_travel_limit <= drive_item.limit;
                    s_valid <= 1'b1;
                    gap_left = (((items_sent / 150) % 4) == 1) ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        sweep_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (reports_due.size() == 0) begin
                    $error("unexpected transaction: status %0d", m_status);
                    fail_count++;
                end else begin
                    want = reports_due.pop_front();
                    compare_field("status", int'(want.status), int'(m_status));
                    compare_field("command_valid", int'(want.cmd_valid),
                                  int'(m_command_valid));
                    compare_field("target_position", int'(want.target),
                                  int'(m_target_position));
                    compare_field("gain_effective", int'(want.gain), int'(m_gain_effective));
                    compare_field("stop_position", int'(want.stop), int'(m_stop_position));
                    compare_field("fault_out", int'(want.fault), int'(m_fault_out));
                end
            end
            if (hold_left == 0 && results_seen >= next_hold_at && control_items.size() > 20)
            begin
                hold_left = LONG_HOLD;
                next_hold_at = results_seen + 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = (((results_seen / 150) % 4) == 3 || $urandom_range(0, 2) != 0)
                             ? 0 : pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("hardstop_seek_sweep_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase_no;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        push_item(OP_TICK, 1'b1, 0, 0, 1'b0, 1'b0, 0);
        push_item(OP_ABORT, 1'b0, 0, 0, 1'b0, 1'b0, 0);
        push_item(OP_RSVD, 1'b1, 0, 0, 1'b0, 1'b0, 0);
        push_item(OP_START, 1'b0, POS_MAX, 15, 1'b1, 1'b1, POS_MAX);
        push_item(OP_TICK, 1'b1, 0, 0, 1'b0, 1'b0, 0);
        push_item(OP_START, 1'b1, POS_MAX - 20, 0, 1'b1, 1'b1, POS_MAX);
        push_item(OP_TICK, 1'b1, POS_MAX - 10, 7, 1'b0, 1'b0, 0);
        push_item(OP_TICK, 1'b0, POS_MIN, 15, 1'b0, 1'b0, 0);
        push_item(OP_TICK, 1'b1, POS_MAX, 0, 1'b0, 1'b0, 0);
        push_item(OP_START, 1'b1, POS_MIN + 30, 0, 1'b0, 1'b0, POS_MIN);
        push_item(OP_START, 1'b1, POS_MIN + 30, 0, 1'b0, 1'b1, POS_MIN);
        push_item(OP_TICK, 1'b1, POS_MIN, 0, 1'b0, 1'b0, 0);
        push_item(OP_START, 1'b1, 0, 0, 1'b1, 1'b0, 0);
        push_item(OP_RSVD, 1'b1, 0, 0, 1'b0, 1'b0, 0);
        push_item(OP_TICK, 1'b1, 100, 8, 1'b0, 1'b0, 0);
        push_item(OP_START, 1'b1, -5000, 0, 1'b0, 1'b0, 0);
        push_item(OP_TICK, 1'b1, -5010, 3, 1'b0, 1'b0, 0);
        push_item(OP_TICK, 1'b1, -5040, 15, 1'b0, 1'b0, 0);
        push_item(OP_START, 1'b1, 12345, 0, 1'b1, 1'b0, -1);
        push_item(OP_TICK, 1'b1, 12360, 0, 1'b1, 1'b1, POS_MAX);
        push_item(OP_ABORT, 1'b1, 0, 0, 1'b0, 1'b0, 0);
        push_item(OP_TICK, 1'b1, 0, 0, 1'b0, 1'b0, 0);
        drain();

        for (phase_no = 0; phase_no < 10; phase_no++) begin
            case (phase_no)
                0: program_regs(65535, 65535, 65535, 4095, 4095, 4095, 8191, 8000);
                1: program_regs(1, 0, 1, 0, 0, 0, 0, 0);
                default: program_regs($urandom_range(8, 250), $urandom_range(0, 40),
                                      $urandom_range(1, 25),
                                      $urandom_range(0, 1) ? $urandom_range(1, 12)
                                                           : $urandom_range(13, 60),
                                      $urandom_range(0, 400), $urandom_range(0, 600),
                                      $urandom_range(0, 3000), $urandom_range(0, 8000));
            endcase
            queue_random(phase_no < 2 ? 100 : 130);
            drain();
        end

        if (fail_count == 0) begin
            $display("hardstop_seek_sweep_unit verification clean");
        end else begin
            $display("hardstop_seek_sweep_unit verification failed");
        end
        $finish;
    end

endmodule
